/* design/mm3_pkg.sv */
// ----------------------------------------------------------------------------
// mm3_pkg: shared types and constants for the murmur3 x64/128 hash block
// Constants of the mixing rounds, the queued block type and helper functions.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam logic [63:0] MixC1  = 64'h87c37b91114253d5;
  localparam logic [63:0] MixC2  = 64'h4cf5ad432745937f;
  localparam logic [63:0] AddOne = 64'h0000000052dce729;
  localparam logic [63:0] AddTwo = 64'h0000000038495ab5;
  localparam logic [63:0] FinM1  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FinM2  = 64'hc4ceb9fe1a85ec53;

  localparam logic [4:0]  FullCount = 5'd16;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  // One block as the back end consumes it: words already masked.
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  count;
    logic        full;
    logic        last;
    logic        start;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] c;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] n);
    rotl64 = (v << n) | (v >> (7'd64 - {1'b0, n}));
  endfunction

  function automatic logic [63:0] fold33(input logic [63:0] v);
    fold33 = v ^ (v >> 33);
  endfunction

  // Keep the low n bytes, n in 0..8.
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    byte_mask = m;
  endfunction

endpackage

/* design/mm3_if.sv */
// ----------------------------------------------------------------------------
// mm3_if: channel interfaces of the hash block
// Block request channel and digest result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mm3_blk_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low_word;
  logic [63:0] block_high_word;
  logic [4:0]  valid_bytes;
  logic        last_block;

  modport source (output valid, block_low_word, block_high_word, valid_bytes, last_block,
                  input ready);
  modport sink   (input valid, block_low_word, block_high_word, valid_bytes, last_block,
                  output ready);
endinterface

interface mm3_dig_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_first;
  logic [63:0] digest_second;

  modport source (output valid, digest_first, digest_second, input ready);
  modport sink   (input valid, digest_first, digest_second, output ready);
endinterface

/* design/mm3_front.sv */
// ----------------------------------------------------------------------------
// mm3_front: request intake and classification
// Normalizes the byte count, masks unused bytes and marks message start.
// ----------------------------------------------------------------------------
module mm3_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  mm3_blk_if.sink        in_i,
  input  logic           q_full_i,
  output logic           push_o,
  output mm3_pkg::item_t item_o
);
  import mm3_pkg::*;

  logic       in_msg_q, in_msg_d;
  logic       full;
  logic [4:0] count;
  logic [3:0] lo_n;
  logic [3:0] hi_n;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  // Short counts only matter on the last request of a message.
  assign full  = !in_i.last_block || (in_i.valid_bytes >= FullCount);
  assign count = full ? FullCount : in_i.valid_bytes;
  assign lo_n  = (count >= 5'd8) ? 4'd8 : count[3:0];
  assign hi_n  = (count >= 5'd16) ? 4'd8 : ((count > 5'd8) ? 4'(count - 5'd8) : 4'd0);

  always_comb begin
    item_o.lo    = in_i.block_low_word & byte_mask(lo_n);
    item_o.hi    = in_i.block_high_word & byte_mask(hi_n);
    item_o.count = count;
    item_o.full  = full;
    item_o.last  = in_i.last_block;
    item_o.start = !in_msg_q;
  end

  always_comb begin
    in_msg_d = in_msg_q;
    if (push_o) begin
      in_msg_d = !in_i.last_block;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_msg_q <= 1'b0;
    end else begin
      in_msg_q <= in_msg_d;
    end
  end

endmodule

/* design/mm3_fifo.sv */
// ----------------------------------------------------------------------------
// mm3_fifo: short queue between front and back end
// Holds classified blocks so intake and hashing stall independently.
// ----------------------------------------------------------------------------
module mm3_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mm3_pkg::item_t  item_i,
  input  logic            pop_i,
  output mm3_pkg::item_t  item_o,
  output mm3_pkg::q_stat_t stat_o
);
  import mm3_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign item_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* design/mm3_mul.sv */
// ----------------------------------------------------------------------------
// mm3_mul: 64-bit modular multiplier built on one 32x32 multiplier
// Forms the low 64 bits of a product in three passes.
// ----------------------------------------------------------------------------
module mm3_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mm3_pkg::mul_req_t req_i,
  output mm3_pkg::mul_rsp_t rsp_o
);
  import mm3_pkg::*;

  localparam logic [1:0] PhLow   = 2'd0;
  localparam logic [1:0] PhCrossA = 2'd1;
  localparam logic [1:0] PhCrossB = 2'd2;

  logic [63:0] a_q, c_q, acc_q;
  logic [1:0]  ph_q;
  logic        busy_q, done_q;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;

  always_comb begin
    case (ph_q)
      PhLow: begin
        op_a = a_q[31:0];
        op_b = c_q[31:0];
      end
      PhCrossA: begin
        op_a = a_q[31:0];
        op_b = c_q[63:32];
      end
      PhCrossB: begin
        op_a = a_q[63:32];
        op_b = c_q[31:0];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = 64'(op_a) * 64'(op_b);

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      c_q <= req_i.c;
    end
    if (busy_q) begin
      if (ph_q == PhLow) begin
        acc_q <= prod;
      end else begin
        acc_q <= acc_q + {prod[31:0], 32'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhLow;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        ph_q   <= PhLow;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (ph_q == PhCrossB) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          ph_q   <= PhLow;
        end else begin
          ph_q <= ph_q + 1'b1;
        end
      end
    end
  end

endmodule

/* design/mm3_back.sv */
// ----------------------------------------------------------------------------
// mm3_back: hashing sequencer
// Runs lane mixing, body round, tail mixing and finalizer for queued blocks.
// ----------------------------------------------------------------------------
module mm3_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [63:0]      seed_i,
  input  mm3_pkg::item_t   item_i,
  input  mm3_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  mm3_dig_if.source        out_o
);
  import mm3_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_L1A  = 18'h00002,
    S_L1B  = 18'h00004,
    S_L2A  = 18'h00008,
    S_L2B  = 18'h00010,
    S_UP1  = 18'h00020,
    S_UP2  = 18'h00040,
    S_UP3  = 18'h00080,
    S_UP4  = 18'h00100,
    S_TAIL = 18'h00200,
    S_FX0  = 18'h00400,
    S_FX1  = 18'h00800,
    S_FM1A = 18'h01000,
    S_FM1B = 18'h02000,
    S_FM2A = 18'h04000,
    S_FM2B = 18'h08000,
    S_FX2  = 18'h10000,
    S_OUT  = 18'h20000
  } state_e;

  state_e      state_q, state_d;
  mul_req_t    mreq;
  mul_rsp_t    mrsp;
  logic [63:0] h1_q, h2_q, tot_q, k1_q, k2_q, hi_q;
  logic        full_q, last_q;
  logic        out_valid_q;
  logic [63:0] dig_first_q, dig_second_q;
  logic        out_load;

  mm3_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    out_load = 1'b0;
    mreq     = '0;
    case (state_q)
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          mreq    = '{start: 1'b1, a: item_i.lo, c: MixC1};
          state_d = S_L1A;
        end
      end
      S_L1A: begin
        if (mrsp.done) begin
          mreq    = '{start: 1'b1, a: rotl64(mrsp.prod, 6'd31), c: MixC2};
          state_d = S_L1B;
        end
      end
      S_L1B: begin
        if (mrsp.done) begin
          mreq    = '{start: 1'b1, a: hi_q, c: MixC2};
          state_d = S_L2A;
        end
      end
      S_L2A: begin
        if (mrsp.done) begin
          mreq    = '{start: 1'b1, a: rotl64(mrsp.prod, 6'd33), c: MixC1};
          state_d = S_L2B;
        end
      end
      S_L2B: begin
        if (mrsp.done) begin
          state_d = full_q ? S_UP1 : S_TAIL;
        end
      end
      S_UP1: state_d = S_UP2;
      S_UP2: state_d = S_UP3;
      S_UP3: state_d = S_UP4;
      S_UP4: state_d = last_q ? S_FX0 : S_IDLE;
      S_TAIL: state_d = last_q ? S_FX0 : S_IDLE;
      S_FX0: state_d = S_FX1;
      S_FX1: begin
        mreq    = '{start: 1'b1, a: fold33(h1_q), c: FinM1};
        state_d = S_FM1A;
      end
      S_FM1A: begin
        if (mrsp.done) begin
          mreq    = '{start: 1'b1, a: fold33(mrsp.prod), c: FinM2};
          state_d = S_FM1B;
        end
      end
      S_FM1B: begin
        if (mrsp.done) begin
          mreq    = '{start: 1'b1, a: fold33(h2_q), c: FinM1};
          state_d = S_FM2A;
        end
      end
      S_FM2A: begin
        if (mrsp.done) begin
          mreq    = '{start: 1'b1, a: fold33(mrsp.prod), c: FinM2};
          state_d = S_FM2B;
        end
      end
      S_FM2B: begin
        if (mrsp.done) begin
          state_d = S_FX2;
        end
      end
      S_FX2: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Working words; no reset, a message start reloads them from the seed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          hi_q   <= item_i.hi;
          full_q <= item_i.full;
          last_q <= item_i.last;
          if (item_i.start) begin
            h1_q  <= seed_i;
            h2_q  <= seed_i;
            tot_q <= 64'(item_i.count);
          end else begin
            tot_q <= tot_q + 64'(item_i.count);
          end
        end
      end
      S_L1B: if (mrsp.done) k1_q <= mrsp.prod;
      S_L2B: if (mrsp.done) k2_q <= mrsp.prod;
      S_UP1: h1_q <= rotl64(h1_q ^ k1_q, 6'd27) + h2_q;
      S_UP2: h1_q <= (h1_q << 2) + h1_q + AddOne;
      S_UP3: h2_q <= rotl64(h2_q ^ k2_q, 6'd31) + h1_q;
      S_UP4: h2_q <= (h2_q << 2) + h2_q + AddTwo;
      S_TAIL: begin
        h1_q <= h1_q ^ k1_q;
        h2_q <= h2_q ^ k2_q;
      end
      S_FX0: begin
        h1_q <= (h1_q ^ tot_q) + (h2_q ^ tot_q);
        h2_q <= h2_q ^ tot_q;
      end
      S_FX1: h2_q <= h2_q + h1_q;
      S_FM1B: if (mrsp.done) h1_q <= fold33(mrsp.prod);
      S_FM2B: if (mrsp.done) h2_q <= fold33(mrsp.prod);
      S_FX2: h1_q <= h1_q + h2_q;
      default: begin
      end
    endcase
    if (out_load) begin
      dig_first_q  <= h1_q;
      dig_second_q <= h2_q + h1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.digest_first  = dig_first_q;
  assign out_o.digest_second = dig_second_q;

endmodule

/* design/murmur3_x64_128_hash.sv */
// ----------------------------------------------------------------------------
// murmur3_x64_128_hash: streaming MurmurHash3 x64 128-bit hash
// Takes 16-byte block requests and returns one 128-bit digest per message.
// ----------------------------------------------------------------------------
//   channel   dir  handshake        payload
//   in_i      in   valid/ready      block_low_word, block_high_word,
//                                   valid_bytes, last_block
//   out_o     out  valid/ready      digest_first, digest_second
//   cfg       in   cfg_we_i only    cfg_wdata_i -> hash seed
//
// A block's time is set by the one 32x32 multiplier, which takes three passes
// per 64-bit product; a last request also runs the finalizer.
// Reset clears the seed, the queue, the sequencer and the output register.
// A two-entry queue lets requests be taken while the sequencer works; the
// sequencer holds its digest while the output register is still occupied.
// ----------------------------------------------------------------------------
module murmur3_x64_128_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  mm3_blk_if.sink     in_i,
  mm3_dig_if.source   out_o
);
  import mm3_pkg::*;

  logic        push;
  logic        pop;
  item_t       front_item;
  item_t       head_item;
  q_stat_t     q_stat;
  logic [63:0] seed_q;

  // Seed register: taken by the sequencer at each message start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // Classify the request and mask bytes beyond the count.
  mm3_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_stat.full),
    .push_o   (push),
    .item_o   (front_item)
  );

  // Decouple intake from hashing.
  mm3_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  // Lane mixing, body round, tail mixing, finalizer and result register.
  mm3_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .seed_i   (seed_q),
    .item_i   (head_item),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_stat_sane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

endmodule
